// ----- rtl/ctp_pkg.sv -----
// ctp_pkg: shared constants, arctangent table and fixed-point helpers
// for the cordic tangent pipeline; no dependencies
package ctp_pkg;

	localparam int DATA_W        = 32;
	localparam int PROD_W        = 64;
	localparam int WIDE_W        = 66;
	localparam int ROT_STAGES    = 31;
	localparam int TABLE_CAP     = 30;
	localparam int CNT_W         = 5;
	localparam int K_W           = 6;
	localparam int Q_POINT       = 28;
	localparam int ANGLE_TABLE_LENGTH_DEF = 20;
	localparam int RECIPROCAL_TERMS_DEF   = 21;

	localparam logic [DATA_W-1:0] ONE_Q30  = 32'h4000_0000;
	localparam logic [DATA_W-1:0] SAT_MAX  = 32'h7FFF_FFFF;
	localparam logic [CNT_W-1:0]  RC_RESET = 5'd20;

	// register index decode
	localparam logic REG_ROTATION_COUNT = 1'b0;

	function automatic logic [DATA_W-1:0] atan_entry(input int idx);
		logic [DATA_W-1:0] r;
		case (idx)
			0: r = 32'd843314857;
			1: r = 32'd497837829;
			2: r = 32'd263043837;
			3: r = 32'd133525159;
			4: r = 32'd67021687;
			5: r = 32'd33543516;
			6: r = 32'd16775851;
			7: r = 32'd8388437;
			8: r = 32'd4194283;
			9: r = 32'd2097149;
			10: r = 32'd1048576;
			11: r = 32'd524288;
			12: r = 32'd262144;
			13: r = 32'd131072;
			14: r = 32'd65536;
			15: r = 32'd32768;
			16: r = 32'd16384;
			17: r = 32'd8192;
			18: r = 32'd4096;
			19: r = 32'd2048;
			20: r = 32'd1024;
			21: r = 32'd512;
			22: r = 32'd256;
			23: r = 32'd128;
			24: r = 32'd64;
			25: r = 32'd32;
			26: r = 32'd16;
			27: r = 32'd8;
			28: r = 32'd4;
			29: r = 32'd2;
			default: r = '0;
		endcase
		return r;
	endfunction

	// angle step used by rotation j (from 1); halves past the table
	function automatic logic [DATA_W-1:0] ang_for(input int j, input int atl);
		logic [DATA_W-1:0] r;
		if (j <= atl)
			r = atan_entry(j - 1);
		else
			r = atan_entry(atl - 1) >> (j - atl);
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
		return v[DATA_W-1] ? (~v + 32'd1) : v;
	endfunction

	// take bits 65:32 of a rounded product and saturate to 31 bits
	function automatic logic [DATA_W-1:0] sat_hi(input logic [WIDE_W-1:0] t);
		logic [WIDE_W-DATA_W-1:0] hi;
		hi = t[WIDE_W-1:DATA_W];
		return (hi > {2'b00, SAT_MAX}) ? SAT_MAX : hi[DATA_W-1:0];
	endfunction

	// redundant sign bits, zero for a zero word
	function automatic logic [CNT_W-1:0] norm_count(input logic [DATA_W-1:0] v);
		logic [CNT_W-1:0] n;
		logic             hit;
		n   = '0;
		hit = 1'b0;
		if (v != '0) begin
			for (int i = DATA_W - 2; i >= 0; i--) begin
				if (!hit && (v[i] == v[DATA_W-1]))
					n = n + 5'd1;
				else
					hit = 1'b1;
			end
		end
		return n;
	endfunction

endpackage

// ----- rtl/ctp_rot_stage.sv -----
// ctp_rot_stage: one cordic rotation with a registered output
// depends on ctp_pkg
module ctp_rot_stage #(
	parameter int J   = 1,
	parameter int ATL = 20
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       ce,
	input  logic                       en,
	input  logic                       valid_in,
	input  logic [ctp_pkg::DATA_W-1:0] theta_in,
	input  logic [ctp_pkg::DATA_W-1:0] c_in,
	input  logic [ctp_pkg::DATA_W-1:0] s_in,
	output logic                       valid_out,
	output logic [ctp_pkg::DATA_W-1:0] theta_out,
	output logic [ctp_pkg::DATA_W-1:0] c_out,
	output logic [ctp_pkg::DATA_W-1:0] s_out
);
	import ctp_pkg::*;

	// factor magnitude is 2^(31-J), times the product shift of two
	localparam int SHIFT = 33 - J;
	localparam logic [DATA_W-1:0] ANG = ang_for(J, ATL);

	logic                f_neg;
	logic [WIDE_W-1:0]   ts, tc;
	logic [DATA_W-1:0]   rs, rc, ps, pc;
	logic [DATA_W-1:0]   theta_nxt, c_nxt, s_nxt;
	logic                valid_s1;
	logic [DATA_W-1:0]   theta_s1, c_s1, s_s1;

	always_comb begin
		f_neg = theta_in[DATA_W-1];
		ts = ({{(WIDE_W-DATA_W){1'b0}}, mag32(s_in)} << SHIFT) + (66'd1 << 17);
		tc = ({{(WIDE_W-DATA_W){1'b0}}, mag32(c_in)} << SHIFT) + (66'd1 << 17);
		rs = sat_hi(ts);
		rc = sat_hi(tc);
		ps = (f_neg ^ s_in[DATA_W-1]) ? (~rs + 32'd1) : rs;
		pc = (f_neg ^ c_in[DATA_W-1]) ? (~rc + 32'd1) : rc;
		if (en) begin
			c_nxt     = c_in - ps;
			s_nxt     = pc + s_in;
			theta_nxt = f_neg ? (theta_in + ANG) : (theta_in - ANG);
		end else begin
			c_nxt     = c_in;
			s_nxt     = s_in;
			theta_nxt = theta_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ce) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			theta_s1 <= theta_nxt;
			c_s1     <= c_nxt;
			s_s1     <= s_nxt;
		end
	end

	assign valid_out = valid_s1;
	assign theta_out = theta_s1;
	assign c_out     = c_s1;
	assign s_out     = s_s1;

endmodule

// ----- rtl/ctp_norm.sv -----
// ctp_norm: two-stage normalization of cosine and sine, seed of the
// reciprocal series and the rescale exponent; depends on ctp_pkg
module ctp_norm (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       ce,
	input  logic                       valid_in,
	input  logic [ctp_pkg::DATA_W-1:0] c_in,
	input  logic [ctp_pkg::DATA_W-1:0] s_in,
	output logic                       valid_out,
	output logic [ctp_pkg::DATA_W-1:0] y_out,
	output logic [ctp_pkg::DATA_W-1:0] acc_out,
	output logic [ctp_pkg::DATA_W-1:0] nn_out,
	output logic [ctp_pkg::K_W-1:0]    k_out,
	output logic                       err_out
);
	import ctp_pkg::*;

	logic                valid_s1, valid_s2;
	logic                err_s1, err_s2;
	logic [CNT_W-1:0]    rd_s1, sn_s1;
	logic [DATA_W-1:0]   c_s1, s_s1;
	logic [DATA_W-1:0]   y_s2, acc_s2, nn_s2;
	logic [K_W-1:0]      k_s2;
	logic [DATA_W-1:0]   nd, y_nxt;

	always_comb begin
		nd    = c_s1 << rd_s1;
		y_nxt = ONE_Q30 - (nd >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (ce) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			err_s1 <= c_in[DATA_W-1];
			rd_s1  <= norm_count(c_in);
			sn_s1  <= norm_count(s_in);
			c_s1   <= c_in;
			s_s1   <= s_in;
			err_s2 <= err_s1;
			y_s2   <= y_nxt;
			acc_s2 <= ONE_Q30 + y_nxt;
			nn_s2  <= s_s1 << sn_s1;
			// exponent: sn - rd + 30, in -1..61, where -1 wraps to 63 in six bits
			k_s2   <= K_W'(sn_s1) - K_W'(rd_s1) + 6'd30;
		end
	end

	assign valid_out = valid_s2;
	assign y_out     = y_s2;
	assign acc_out   = acc_s2;
	assign nn_out    = nn_s2;
	assign k_out     = k_s2;
	assign err_out   = err_s2;

endmodule

// ----- rtl/ctp_mul_stage.sv -----
// ctp_mul_stage: two-stage sign-magnitude 32x32 product with rounding,
// saturation and an added bias; sideband travels alongside; depends on ctp_pkg
module ctp_mul_stage #(
	parameter int          SH     = 2,
	parameter logic [31:0] BIAS   = 32'h0,
	parameter int          SIDE_W = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       ce,
	input  logic                       valid_in,
	input  logic [ctp_pkg::DATA_W-1:0] a_in,
	input  logic [ctp_pkg::DATA_W-1:0] b_in,
	input  logic [SIDE_W-1:0]          side_in,
	output logic                       valid_out,
	output logic [ctp_pkg::DATA_W-1:0] r_out,
	output logic [SIDE_W-1:0]          side_out
);
	import ctp_pkg::*;

	logic                valid_s1, valid_s2;
	logic [PROD_W-1:0]   prod_s1;
	logic                neg_s1;
	logic [SIDE_W-1:0]   side_s1, side_s2;
	logic [DATA_W-1:0]   r_s2;
	logic [WIDE_W-1:0]   t;
	logic [DATA_W-1:0]   m, res;

	always_comb begin
		t   = ({{(WIDE_W-PROD_W){1'b0}}, prod_s1} << SH) + (66'd1 << (15 + SH));
		m   = sat_hi(t);
		res = neg_s1 ? (~m + 32'd1) : m;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (ce) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			prod_s1 <= PROD_W'(mag32(a_in)) * PROD_W'(mag32(b_in));
			neg_s1  <= a_in[DATA_W-1] ^ b_in[DATA_W-1];
			side_s1 <= side_in;
			r_s2    <= res + BIAS;
			side_s2 <= side_s1;
		end
	end

	assign valid_out = valid_s2;
	assign r_out     = r_s2;
	assign side_out  = side_s2;

endmodule

// ----- rtl/cordic_tangent_q28_top.sv -----
// cordic_tangent_q28_top: pipelined tangent of a q28 angle by cordic
// rotation and a taylor-series reciprocal; depends on ctp_pkg and all ctp_ modules
//
//   channel   signals                              dir   meaning
//   request   in_valid, in_stall, angle_q28        in    one angle per request
//   result    out_valid, out_stall, tangent_q28,   out   tangent, error flag
//             divide_error
//   config    apb: psel penable pwrite paddr ...   in    rotation_count at 0x0
//
// one request enters every cycle unless the pipeline is stalled; the stages are
// 31 rotation stages, 2 normalize stages, 2 per series term, 2 for the final
// product and 1 output register
// reset clears valid bits and loads rotation_count with 20
// a stalled result freezes the whole pipeline; no request is lost or repeated
module cordic_tangent_q28_top #(
	parameter int ANGLE_TABLE_LENGTH = ctp_pkg::ANGLE_TABLE_LENGTH_DEF,
	parameter int RECIPROCAL_TERMS   = ctp_pkg::RECIPROCAL_TERMS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [29:0] angle_q28,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] tangent_q28,
	output logic        divide_error,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ctp_pkg::*;

	// side word through the series: y, normalized sine, exponent, error
	localparam int SIDE_W = 2 * DATA_W + K_W + 1;
	localparam int QS_W   = K_W + 1;

	logic [CNT_W-1:0]  rotation_count_q;
	logic              ce;

	// rotation chain
	logic              rv [0:ROT_STAGES];
	logic [DATA_W-1:0] rtheta [0:ROT_STAGES];
	logic [DATA_W-1:0] rcos [0:ROT_STAGES];
	logic [DATA_W-1:0] rsin [0:ROT_STAGES];

	// normalize outputs
	logic              nv;
	logic [DATA_W-1:0] ny, nacc, nnn;
	logic [K_W-1:0]    nk;
	logic              nerr;

	// reciprocal series chain
	logic              tv [0:RECIPROCAL_TERMS];
	logic [DATA_W-1:0] tacc [0:RECIPROCAL_TERMS];
	logic [SIDE_W-1:0] tside [0:RECIPROCAL_TERMS];

	// final product
	logic              qv;
	logic [DATA_W-1:0] q;
	logic [QS_W-1:0]   qside;
	logic [K_W-1:0]    qk;
	logic              qerr;

	logic [DATA_W-1:0] t_nxt;
	logic [K_W-1:0]    rsh;
	logic              out_valid_q;
	logic [DATA_W-1:0] tangent_q;
	logic              error_q;

	// config register, written on the apb access phase
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_count_q <= RC_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_ROTATION_COUNT)) begin
			rotation_count_q <= pwdata[CNT_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_ROTATION_COUNT) ?
		{{(DATA_W-CNT_W){1'b0}}, rotation_count_q} : '0;

	// whole pipeline advances unless a finished result is held
	assign ce       = !(out_valid_q && out_stall);
	assign in_stall = !ce;

	// rotations start from (1.0, 0) with the angle moved to q30
	assign rv[0]     = in_valid;
	assign rtheta[0] = {angle_q28, 2'b00};
	assign rcos[0]   = ONE_Q30;
	assign rsin[0]   = '0;

	for (genvar j = 1; j <= ROT_STAGES; j++) begin : g_rot
		ctp_rot_stage #(
			.J   (j),
			.ATL (ANGLE_TABLE_LENGTH)
		) u_rot (
			.clk       (clk),
			.arst_n    (arst_n),
			.ce        (ce),
			.en        (rotation_count_q >= CNT_W'(j)),
			.valid_in  (rv[j-1]),
			.theta_in  (rtheta[j-1]),
			.c_in      (rcos[j-1]),
			.s_in      (rsin[j-1]),
			.valid_out (rv[j]),
			.theta_out (rtheta[j]),
			.c_out     (rcos[j]),
			.s_out     (rsin[j])
		);
	end

	ctp_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.valid_in  (rv[ROT_STAGES]),
		.c_in      (rcos[ROT_STAGES]),
		.s_in      (rsin[ROT_STAGES]),
		.valid_out (nv),
		.y_out     (ny),
		.acc_out   (nacc),
		.nn_out    (nnn),
		.k_out     (nk),
		.err_out   (nerr)
	);

	assign tv[0]    = nv;
	assign tacc[0]  = nacc;
	assign tside[0] = {ny, nnn, nk, nerr};

	// acc = 1.0 + y * acc per term
	for (genvar i = 0; i < RECIPROCAL_TERMS; i++) begin : g_term
		ctp_mul_stage #(
			.SH     (2),
			.BIAS   (ONE_Q30),
			.SIDE_W (SIDE_W)
		) u_term (
			.clk       (clk),
			.arst_n    (arst_n),
			.ce        (ce),
			.valid_in  (tv[i]),
			.a_in      (tside[i][SIDE_W-1 -: DATA_W]),
			.b_in      (tacc[i]),
			.side_in   (tside[i]),
			.valid_out (tv[i+1]),
			.r_out     (tacc[i+1]),
			.side_out  (tside[i+1])
		);
	end

	// normalized sine times reciprocal
	ctp_mul_stage #(
		.SH     (1),
		.BIAS   (32'h0),
		.SIDE_W (QS_W)
	) u_quot (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.valid_in  (tv[RECIPROCAL_TERMS]),
		.a_in      (tside[RECIPROCAL_TERMS][SIDE_W-DATA_W-1 -: DATA_W]),
		.b_in      (tacc[RECIPROCAL_TERMS]),
		.side_in   (tside[RECIPROCAL_TERMS][QS_W-1:0]),
		.valid_out (qv),
		.r_out     (q),
		.side_out  (qside)
	);

	assign qk   = qside[QS_W-1:1];
	assign qerr = qside[0];

	// rescale to q28: zero on error, else arithmetic right shift capped at 31, or wrapping left shift
	always_comb begin
		rsh = qk - K_W'(Q_POINT);
		if (qerr)
			t_nxt = '0;
		else if (qk > K_W'(Q_POINT))
			t_nxt = $signed(q) >>> ((rsh > 6'd31) ? 5'd31 : rsh[CNT_W-1:0]);
		else
			t_nxt = q << (K_W'(Q_POINT) - qk);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ce) begin
			out_valid_q <= qv;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			tangent_q <= t_nxt;
			error_q   <= qerr;
		end
	end

	assign out_valid    = out_valid_q;
	assign tangent_q28  = tangent_q;
	assign divide_error = error_q;

	// a flagged result always carries a zero tangent
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && divide_error) |-> (tangent_q28 == '0))
		else $error("error result with nonzero tangent");

	// config write lands in the rotation count
	assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && (paddr[2] == REG_ROTATION_COUNT))
		|=> (rotation_count_q == $past(pwdata[CNT_W-1:0])))
		else $error("rotation count write lost");

	// a held result keeps the input side stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> in_stall)
		else $error("request taken while result held");

endmodule
